FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define LRK4_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define LRK4_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lrk4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lrk4_pkg;

   localparam int COORD_W    = 48;
   localparam int WIDE_W     = 64;
   localparam int STEP_W     = 32;
   localparam int DT_W       = 36;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 176;

   localparam logic signed [63:0] WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] WIDE_MIN = 64'shC000_0000_0000_0000;

   localparam logic [2:0] DIV_BY_2 = 3'd2;
   localparam logic [2:0] DIV_BY_3 = 3'd3;
   localparam logic [2:0] DIV_BY_6 = 3'd6;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_DX,
      OP_MXZ,
      OP_DY,
      OP_DIV3,
      OP_MXY,
      OP_DZ,
      OP_ACC,
      OP_MKD,
      OP_HALF,
      OP_PT,
      OP_MSD,
      OP_DIV6,
      OP_POS,
      OP_PUB
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       start;
      logic [1:0] comp;
      logic [1:0] stage;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } dp_status_type;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_INIT = 16'h0002,
      ST_DX   = 16'h0004,
      ST_MXZ  = 16'h0008,
      ST_DY   = 16'h0010,
      ST_DIV3 = 16'h0020,
      ST_MXY  = 16'h0040,
      ST_DZ   = 16'h0080,
      ST_ACC  = 16'h0100,
      ST_MKD  = 16'h0200,
      ST_HALF = 16'h0400,
      ST_PT   = 16'h0800,
      ST_MSD  = 16'h1000,
      ST_DIV6 = 16'h2000,
      ST_POS  = 16'h4000,
      ST_PUB  = 16'h8000
   } ctl_state_type;

endpackage
`default_nettype wire

FILE: sv/lorenz_rk4_step_unit.sv
// A load item passes the idle and publish states before it is presented; a step item runs
// 20 products (4 partial products each on one 32x32 multiplier), 13 divisions
// (8 quotient bits per cycle) and 30 other controller steps before it is presented.
// One item in flight: a new request is taken only when the controller is back in idle.
// A result held by rsp_tready stalls the next item until it is taken.
// Reset (synchronous, active high): x = 1.01, y = z = 0, count 0, dt = 0.01.
`timescale 1ns / 1ps
`default_nettype none
module lorenz_rk4_step_unit #(
   parameter int FRAC_BITS = 40
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [143:0]  req_tdata,   // load_x, load_y, load_z
   input  wire logic [0:0]    req_tuser,   // op
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [175:0]       rsp_tdata,   // out_x, out_y, out_z, steps_done
   output logic [0:0]         rsp_tuser,   // overflow
   input  wire logic          csr_we,
   input  wire logic [35:0]   csr_wdata    // time_step
);

   lrk4_pkg::dp_cmd_type    cmd;
   lrk4_pkg::dp_status_type status;
   logic [47:0] out_x, out_y, out_z;
   logic [31:0] steps_done;
   logic        overflow;

   lrk4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_is_load(req_tuser[0]),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .cmd       (cmd),
      .status    (status)
   );

   lrk4_dpath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .load_x    (req_tdata[47:0]),
      .load_y    (req_tdata[95:48]),
      .load_z    (req_tdata[143:96]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_z     (out_z),
      .steps_done(steps_done),
      .overflow  (overflow)
   );

   assign rsp_tdata = {steps_done, out_z, out_y, out_x};
   assign rsp_tuser = overflow;

endmodule
`default_nettype wire

FILE: sv/lrk4_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module lrk4_mul #(
   parameter int FRAC_BITS = 40
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] a_in,
   input  wire logic signed [63:0] b_in,
   output logic signed [63:0]      result,
   output logic                    over,
   output logic                    done
);

   logic [63:0]        ma_ff, mb_ff;
   logic               neg_ff;
   logic [127:0]       acc_ff;
   logic [63:0]        pp_ff;
   logic [1:0]         sh_ff;
   logic               pp_vld_ff;
   logic [2:0]         cnt_ff;
   logic               busy_ff, done_ff;
   logic signed [63:0] res_ff;
   logic               over_ff;

   logic [63:0]        a_mag, b_mag;
   logic [31:0]        a_half, b_half;
   logic [63:0]        pp_in;
   logic [127:0]       pp_shift;
   logic [127:0]       q_full;
   logic [127:0]       lim;
   logic               over_in;
   logic signed [63:0] res_in;

   assign a_mag  = a_in[63] ? (~a_in + 64'd1) : a_in;
   assign b_mag  = b_in[63] ? (~b_in + 64'd1) : b_in;
   assign a_half = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_half = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign pp_in  = a_half * b_half;

   always_comb begin
      case (sh_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   // rounding bias is preloaded into the accumulator
   assign q_full  = acc_ff >> FRAC_BITS;
   assign lim     = neg_ff ? (128'd1 << 62) : ((128'd1 << 62) - 128'd1);
   assign over_in = q_full > lim;

   always_comb begin
      if (over_in) begin
         res_in = neg_ff ? lrk4_pkg::WIDE_MIN : lrk4_pkg::WIDE_MAX;
      end else if (neg_ff) begin
         res_in = -$signed(q_full[63:0]);
      end else begin
         res_in = $signed(q_full[63:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= 3'd0;
         pp_vld_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= 3'd0;
            pp_vld_ff <= 1'b0;
         end else if (busy_ff) begin
            cnt_ff    <= cnt_ff + 3'd1;
            pp_vld_ff <= cnt_ff < 3'd4;
            if (cnt_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= a_mag;
         mb_ff  <= b_mag;
         neg_ff <= a_in[63] ^ b_in[63];
         acc_ff <= 128'd1 << (FRAC_BITS - 1);
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff <= pp_in;
            sh_ff <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
         end
         if (pp_vld_ff) begin
            acc_ff <= acc_ff + pp_shift;
         end
         if (cnt_ff == 3'd5) begin
            res_ff  <= res_in;
            over_ff <= over_in;
         end
      end
   end

   assign result = res_ff;
   assign over   = over_ff;
   assign done   = done_ff;

endmodule
`default_nettype wire

FILE: sv/lrk4_div.sv
`timescale 1ns / 1ps
`default_nettype none
module lrk4_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] v_in,
   input  wire logic [2:0]         n_in,
   output logic signed [63:0]      result,
   output logic                    over,
   output logic                    done
);

   logic [63:0]        m_ff, q_ff;
   logic [2:0]         rem_ff, n_ff;
   logic               neg_ff;
   logic [3:0]         cnt_ff;
   logic               busy_ff, done_ff;
   logic signed [63:0] res_ff;
   logic               over_ff;

   logic [63:0]        v_mag;
   logic [7:0]         qbits;
   logic [2:0]         rem_next;
   logic               round_up;
   logic [63:0]        q_rnd;
   logic [63:0]        lim;
   logic               over_in;
   logic signed [63:0] res_in;

   assign v_mag = v_in[63] ? (~v_in + 64'd1) : v_in;

   // eight restoring steps per cycle, MSB first
   always_comb begin
      logic [3:0] r;
      r     = {1'b0, rem_ff};
      qbits = 8'd0;
      for (int i = 0; i < 8; i++) begin
         r = {r[2:0], m_ff[63 - i]};
         if (r >= {1'b0, n_ff}) begin
            r            = r - {1'b0, n_ff};
            qbits[7 - i] = 1'b1;
         end
      end
      rem_next = r[2:0];
   end

   assign round_up = {rem_ff, 1'b0} >= {1'b0, n_ff};
   assign q_rnd    = q_ff + {63'd0, round_up};
   assign lim      = neg_ff ? (64'd1 << 62) : ((64'd1 << 62) - 64'd1);
   assign over_in  = q_rnd > lim;

   always_comb begin
      if (over_in) begin
         res_in = neg_ff ? lrk4_pkg::WIDE_MIN : lrk4_pkg::WIDE_MAX;
      end else if (neg_ff) begin
         res_in = -$signed(q_rnd);
      end else begin
         res_in = $signed(q_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         m_ff   <= v_mag;
         q_ff   <= 64'd0;
         rem_ff <= 3'd0;
         n_ff   <= n_in;
         neg_ff <= v_in[63];
      end else if (busy_ff) begin
         if (cnt_ff < 4'd8) begin
            m_ff   <= m_ff << 8;
            q_ff   <= {q_ff[55:0], qbits};
            rem_ff <= rem_next;
         end else begin
            res_ff  <= res_in;
            over_ff <= over_in;
         end
      end
   end

   assign result = res_ff;
   assign over   = over_ff;
   assign done   = done_ff;

endmodule
`default_nettype wire

FILE: sv/lrk4_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lrk4_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic                     in_is_load,
   output logic                          in_ready,
   input  wire logic                     out_ready,
   output logic                          out_valid,
   output lrk4_pkg::dp_cmd_type          cmd,
   input  wire lrk4_pkg::dp_status_type  status
);

   lrk4_pkg::ctl_state_type state_ff, state_in;
   logic [1:0] stage_ff, stage_in;
   logic [1:0] comp_ff, comp_in;
   logic       issued_ff;
   logic       rsp_valid_ff;
   logic       unit_state;
   logic       unit_done;
   logic       pub_fire;

   assign unit_done  = status.mul_done | status.div_done;
   assign unit_state = (state_ff == lrk4_pkg::ST_MXZ) || (state_ff == lrk4_pkg::ST_DIV3) ||
                       (state_ff == lrk4_pkg::ST_MXY) || (state_ff == lrk4_pkg::ST_MKD) ||
                       (state_ff == lrk4_pkg::ST_HALF) || (state_ff == lrk4_pkg::ST_MSD) ||
                       (state_ff == lrk4_pkg::ST_DIV6);

   always_comb begin
      state_in  = state_ff;
      stage_in  = stage_ff;
      comp_in   = comp_ff;
      pub_fire  = 1'b0;
      cmd.op    = lrk4_pkg::OP_NONE;
      cmd.comp  = comp_ff;
      cmd.stage = stage_ff;
      unique case (state_ff)
         lrk4_pkg::ST_IDLE: begin
            if (in_valid) begin
               if (in_is_load) begin
                  cmd.op   = lrk4_pkg::OP_LOAD;
                  state_in = lrk4_pkg::ST_PUB;
               end else begin
                  state_in = lrk4_pkg::ST_INIT;
               end
            end
         end
         lrk4_pkg::ST_INIT: begin
            cmd.op   = lrk4_pkg::OP_INIT;
            stage_in = 2'd0;
            comp_in  = 2'd0;
            state_in = lrk4_pkg::ST_DX;
         end
         lrk4_pkg::ST_DX: begin
            cmd.op   = lrk4_pkg::OP_DX;
            state_in = lrk4_pkg::ST_MXZ;
         end
         lrk4_pkg::ST_MXZ: begin
            cmd.op = lrk4_pkg::OP_MXZ;
            if (unit_done) state_in = lrk4_pkg::ST_DY;
         end
         lrk4_pkg::ST_DY: begin
            cmd.op   = lrk4_pkg::OP_DY;
            state_in = lrk4_pkg::ST_DIV3;
         end
         lrk4_pkg::ST_DIV3: begin
            cmd.op = lrk4_pkg::OP_DIV3;
            if (unit_done) state_in = lrk4_pkg::ST_MXY;
         end
         lrk4_pkg::ST_MXY: begin
            cmd.op = lrk4_pkg::OP_MXY;
            if (unit_done) state_in = lrk4_pkg::ST_DZ;
         end
         lrk4_pkg::ST_DZ: begin
            cmd.op   = lrk4_pkg::OP_DZ;
            state_in = lrk4_pkg::ST_ACC;
         end
         lrk4_pkg::ST_ACC: begin
            cmd.op   = lrk4_pkg::OP_ACC;
            comp_in  = 2'd0;
            state_in = (stage_ff == 2'd3) ? lrk4_pkg::ST_MSD : lrk4_pkg::ST_MKD;
         end
         lrk4_pkg::ST_MKD: begin
            cmd.op = lrk4_pkg::OP_MKD;
            if (unit_done) begin
               state_in = stage_ff[1] ? lrk4_pkg::ST_PT : lrk4_pkg::ST_HALF;
            end
         end
         lrk4_pkg::ST_HALF: begin
            cmd.op = lrk4_pkg::OP_HALF;
            if (unit_done) state_in = lrk4_pkg::ST_PT;
         end
         lrk4_pkg::ST_PT: begin
            cmd.op = lrk4_pkg::OP_PT;
            if (comp_ff == 2'd2) begin
               comp_in  = 2'd0;
               stage_in = stage_ff + 2'd1;
               state_in = lrk4_pkg::ST_DX;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = lrk4_pkg::ST_MKD;
            end
         end
         lrk4_pkg::ST_MSD: begin
            cmd.op = lrk4_pkg::OP_MSD;
            if (unit_done) state_in = lrk4_pkg::ST_DIV6;
         end
         lrk4_pkg::ST_DIV6: begin
            cmd.op = lrk4_pkg::OP_DIV6;
            if (unit_done) state_in = lrk4_pkg::ST_POS;
         end
         lrk4_pkg::ST_POS: begin
            cmd.op = lrk4_pkg::OP_POS;
            if (comp_ff == 2'd2) begin
               state_in = lrk4_pkg::ST_PUB;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = lrk4_pkg::ST_MSD;
            end
         end
         lrk4_pkg::ST_PUB: begin
            if (!rsp_valid_ff || out_ready) begin
               cmd.op   = lrk4_pkg::OP_PUB;
               pub_fire = 1'b1;
               state_in = lrk4_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrk4_pkg::ST_IDLE;
         end
      endcase
      cmd.start = unit_state && !issued_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrk4_pkg::ST_IDLE;
         stage_ff     <= 2'd0;
         comp_ff      <= 2'd0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         comp_ff  <= comp_in;
         if (unit_done) begin
            issued_ff <= 1'b0;
         end else if (cmd.start) begin
            issued_ff <= 1'b1;
         end
         if (pub_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign in_ready  = state_ff == lrk4_pkg::ST_IDLE;
   assign out_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: sv/lrk4_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module lrk4_dpath #(
   parameter int FRAC_BITS = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lrk4_pkg::dp_cmd_type       cmd,
   output lrk4_pkg::dp_status_type         status,
   input  wire logic [47:0]                load_x,
   input  wire logic [47:0]                load_y,
   input  wire logic [47:0]                load_z,
   input  wire logic                       csr_we,
   input  wire logic [35:0]                csr_wdata,
   output logic [47:0]                     out_x,
   output logic [47:0]                     out_y,
   output logic [47:0]                     out_z,
   output logic [31:0]                     steps_done,
   output logic                            overflow
);

   localparam logic [71:0] TS_FULL  = ((72'd1 << FRAC_BITS) + 72'd50) / 72'd100;
   localparam logic [71:0] PX_FULL  = ((72'd101 << FRAC_BITS) + 72'd50) / 72'd100;
   localparam logic [35:0] TS_RESET = (TS_FULL > 72'hF_FFFF_FFFF) ?
                                      36'hF_FFFF_FFFF : TS_FULL[35:0];
   localparam logic [47:0] PX_RESET = (PX_FULL > 72'h7FFF_FFFF_FFFF) ?
                                      48'h7FFF_FFFF_FFFF : PX_FULL[47:0];
   localparam logic signed [63:0] C_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] C_MIN64 = 64'shFFFF_8000_0000_0000;

   function automatic logic signed [63:0] sx(input logic [47:0] v);
      return $signed({{16{v[47]}}, v});
   endfunction

   function automatic logic wover(input logic signed [63:0] v);
      return (v > lrk4_pkg::WIDE_MAX) || (v < lrk4_pkg::WIDE_MIN);
   endfunction

   function automatic logic signed [63:0] satw(input logic signed [63:0] v);
      if (v > lrk4_pkg::WIDE_MAX) return lrk4_pkg::WIDE_MAX;
      if (v < lrk4_pkg::WIDE_MIN) return lrk4_pkg::WIDE_MIN;
      return v;
   endfunction

   function automatic logic cover48(input logic signed [63:0] v);
      return (v > C_MAX64) || (v < C_MIN64);
   endfunction

   function automatic logic [47:0] sat48(input logic signed [63:0] v);
      if (v > C_MAX64) return C_MAX64[47:0];
      if (v < C_MIN64) return C_MIN64[47:0];
      return v[47:0];
   endfunction

   // {clamped, new sum}
   function automatic logic [64:0] acc_step(input logic signed [63:0] s,
                                            input logic signed [63:0] k,
                                            input logic [1:0] stage);
      logic signed [63:0] kk;
      logic signed [63:0] t;
      logic               o;
      if (stage == 2'd0) return {1'b0, k};
      if (stage == 2'd3) begin
         t = s + k;
         return {wover(t), satw(t)};
      end
      kk = k <<< 1;
      o  = wover(kk);
      t  = s + satw(kk);
      return {o | wover(t), satw(t)};
   endfunction

   logic [47:0]        pos_x_ff, pos_y_ff, pos_z_ff;
   logic [47:0]        pt_x_ff, pt_y_ff, pt_z_ff;
   logic signed [63:0] k_x_ff, k_y_ff, k_z_ff;
   logic signed [63:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [63:0] t0_ff, t1_ff;
   logic [31:0]        cnt_ff;
   logic               ovf_ff;
   logic [35:0]        dt_ff;
   logic [47:0]        out_x_ff, out_y_ff, out_z_ff;
   logic [31:0]        out_cnt_ff;
   logic               out_ovf_ff;

   logic signed [63:0] mul_a, mul_b, mul_res;
   logic               mul_start, mul_over, mul_done;
   logic signed [63:0] div_v, div_res;
   logic [2:0]         div_n;
   logic               div_start, div_over, div_done;

   logic signed [63:0] k_sel, sum_sel, pos_sel;
   logic signed [63:0] diff_yx, dx_val, x64, dy_raw, dz_raw, pn;
   logic [64:0]        acc_x, acc_y, acc_z;
   logic               ovf_set;

   always_comb begin
      case (cmd.comp)
         2'd0: begin
            k_sel = k_x_ff; sum_sel = sum_x_ff; pos_sel = sx(pos_x_ff);
         end
         2'd1: begin
            k_sel = k_y_ff; sum_sel = sum_y_ff; pos_sel = sx(pos_y_ff);
         end
         default: begin
            k_sel = k_z_ff; sum_sel = sum_z_ff; pos_sel = sx(pos_z_ff);
         end
      endcase
   end

   assign diff_yx = sx(pt_y_ff) - sx(pt_x_ff);
   assign dx_val  = (diff_yx <<< 3) + (diff_yx <<< 1);
   assign x64     = sx(pt_x_ff);
   assign dy_raw  = (x64 <<< 5) - (x64 <<< 2) - sx(pt_y_ff) - t0_ff;
   assign dz_raw  = t0_ff - t1_ff;
   assign pn      = pos_sel + t0_ff;
   assign acc_x   = acc_step(sum_x_ff, k_x_ff, cmd.stage);
   assign acc_y   = acc_step(sum_y_ff, k_y_ff, cmd.stage);
   assign acc_z   = acc_step(sum_z_ff, k_z_ff, cmd.stage);

   always_comb begin
      mul_a   = x64;
      mul_b   = sx(pt_y_ff);
      div_v   = t0_ff;
      div_n   = lrk4_pkg::DIV_BY_2;
      ovf_set = 1'b0;
      unique case (cmd.op)
         lrk4_pkg::OP_MXZ: mul_b = sx(pt_z_ff);
         lrk4_pkg::OP_MKD: begin
            mul_a = k_sel;
            mul_b = $signed({28'd0, dt_ff});
         end
         lrk4_pkg::OP_MSD: begin
            mul_a = sum_sel;
            mul_b = $signed({28'd0, dt_ff});
         end
         lrk4_pkg::OP_DIV3: begin
            div_v = sx(pt_z_ff) <<< 3;
            div_n = lrk4_pkg::DIV_BY_3;
         end
         lrk4_pkg::OP_DIV6: div_n = lrk4_pkg::DIV_BY_6;
         lrk4_pkg::OP_DY:   ovf_set = wover(dy_raw);
         lrk4_pkg::OP_DZ:   ovf_set = wover(dz_raw);
         lrk4_pkg::OP_ACC:  ovf_set = acc_x[64] | acc_y[64] | acc_z[64];
         lrk4_pkg::OP_PT,
         lrk4_pkg::OP_POS:  ovf_set = cover48(pn);
         default: ;
      endcase
      if (mul_done) ovf_set = ovf_set | mul_over;
      if (div_done) ovf_set = ovf_set | div_over;
   end

   assign mul_start = cmd.start && ((cmd.op == lrk4_pkg::OP_MXZ) ||
                      (cmd.op == lrk4_pkg::OP_MXY) || (cmd.op == lrk4_pkg::OP_MKD) ||
                      (cmd.op == lrk4_pkg::OP_MSD));
   assign div_start = cmd.start && ((cmd.op == lrk4_pkg::OP_DIV3) ||
                      (cmd.op == lrk4_pkg::OP_HALF) || (cmd.op == lrk4_pkg::OP_DIV6));

   lrk4_mul #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .result(mul_res),
      .over  (mul_over),
      .done  (mul_done)
   );

   lrk4_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .v_in  (div_v),
      .n_in  (div_n),
      .result(div_res),
      .over  (div_over),
      .done  (div_done)
   );

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= PX_RESET;
         pos_y_ff <= 48'd0;
         pos_z_ff <= 48'd0;
         cnt_ff   <= 32'd0;
         ovf_ff   <= 1'b0;
         dt_ff    <= TS_RESET;
      end else begin
         if (csr_we) dt_ff <= csr_wdata;
         case (cmd.op)
            lrk4_pkg::OP_LOAD: begin
               pos_x_ff <= load_x;
               pos_y_ff <= load_y;
               pos_z_ff <= load_z;
               cnt_ff   <= 32'd0;
               ovf_ff   <= 1'b0;
            end
            lrk4_pkg::OP_INIT: ovf_ff <= 1'b0;
            lrk4_pkg::OP_POS: begin
               case (cmd.comp)
                  2'd0:    pos_x_ff <= sat48(pn);
                  2'd1:    pos_y_ff <= sat48(pn);
                  default: pos_z_ff <= sat48(pn);
               endcase
               if (cmd.comp == 2'd2 && cnt_ff != 32'hFFFF_FFFF) cnt_ff <= cnt_ff + 32'd1;
               ovf_ff <= ovf_ff | ovf_set;
            end
            default: ovf_ff <= ovf_ff | ovf_set;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         lrk4_pkg::OP_INIT: begin
            pt_x_ff <= pos_x_ff;
            pt_y_ff <= pos_y_ff;
            pt_z_ff <= pos_z_ff;
         end
         lrk4_pkg::OP_DX: k_x_ff <= dx_val;
         lrk4_pkg::OP_DY: k_y_ff <= satw(dy_raw);
         lrk4_pkg::OP_DZ: k_z_ff <= satw(dz_raw);
         lrk4_pkg::OP_ACC: begin
            sum_x_ff <= acc_x[63:0];
            sum_y_ff <= acc_y[63:0];
            sum_z_ff <= acc_z[63:0];
         end
         lrk4_pkg::OP_PT: begin
            case (cmd.comp)
               2'd0:    pt_x_ff <= sat48(pn);
               2'd1:    pt_y_ff <= sat48(pn);
               default: pt_z_ff <= sat48(pn);
            endcase
         end
         lrk4_pkg::OP_PUB: begin
            out_x_ff   <= pos_x_ff;
            out_y_ff   <= pos_y_ff;
            out_z_ff   <= pos_z_ff;
            out_cnt_ff <= cnt_ff;
            out_ovf_ff <= ovf_ff;
         end
         default: ;
      endcase
      if (mul_done) t0_ff <= mul_res;
      if (div_done) begin
         if (cmd.op == lrk4_pkg::OP_DIV3) begin
            t1_ff <= div_res;
         end else begin
            t0_ff <= div_res;
         end
      end
   end

   assign out_x      = out_x_ff;
   assign out_y      = out_y_ff;
   assign out_z      = out_z_ff;
   assign steps_done = out_cnt_ff;
   assign overflow   = out_ovf_ff;

endmodule
`default_nettype wire

FILE: sv/lrk4_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lrk4_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [175:0] rsp_tdata
);

   `LRK4_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")
   `LRK4_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp changed")
   `LRK4_ASSERT(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "second item taken")
   `LRK4_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind lorenz_rk4_step_unit lrk4_checker u_lrk4_checker (.*);
`default_nettype wire
